@@ sv/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

  // Table geometry: one used bit per frame, 64 frames per memory word.
  localparam int BITMAP_WORDS = 512;
  localparam int WORD_W       = 64;
  localparam int BIT_AW       = $clog2(WORD_W);
  localparam int WORD_AW      = $clog2(BITMAP_WORDS);
  localparam int TOTAL_FRAMES = BITMAP_WORDS * WORD_W;

  // The word-full flags are searched in two levels: groups, then words.
  localparam int GROUP_SIZE = 32;
  localparam int NUM_GROUPS = BITMAP_WORDS / GROUP_SIZE;
  localparam int GRP_AW     = $clog2(NUM_GROUPS);
  localparam int SLOT_AW    = $clog2(GROUP_SIZE);

  // Field widths of the stream words.
  localparam int MODE_W       = 2;
  localparam int FRAME_IN_W   = 16;
  localparam int FRAME_OUT_W  = 15;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 16;
  localparam int OUT_FIELDS_W = FRAME_OUT_W + STATUS_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESERVE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Update of one word-full flag after a write-back.
  typedef struct packed {
    logic               we;
    logic [WORD_AW-1:0] addr;
    logic               full;
  } full_upd_t;

  // Lowest clear bit of a bitmap word.
  function automatic logic [BIT_AW-1:0] lowest_zero_bit(input logic [WORD_W-1:0] w);
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!w[b]) idx = BIT_AW'(b);
    end
    return idx;
  endfunction

  // Lowest word within a group that is not full.
  function automatic logic [SLOT_AW-1:0] lowest_zero_slot(input logic [GROUP_SIZE-1:0] f);
    logic [SLOT_AW-1:0] idx;
    idx = '0;
    for (int s = GROUP_SIZE - 1; s >= 0; s--) begin
      if (!f[s]) idx = SLOT_AW'(s);
    end
    return idx;
  endfunction

  // Lowest group that still holds a word that is not full.
  function automatic logic [GRP_AW-1:0] lowest_zero_group(input logic [NUM_GROUPS-1:0] g);
    logic [GRP_AW-1:0] idx;
    idx = '0;
    for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
      if (!g[k]) idx = GRP_AW'(k);
    end
    return idx;
  endfunction

endpackage

@@ sv/bfa_bitmap_ram.sv @@
`timescale 1ns / 1ps

module bfa_bitmap_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bfa_pkg::WORD_AW-1:0] waddr,
  input  logic [bfa_pkg::WORD_W-1:0]  wdata,
  input  logic                        re,
  input  logic [bfa_pkg::WORD_AW-1:0] raddr,
  output logic [bfa_pkg::WORD_W-1:0]  rdata
);

  logic [bfa_pkg::WORD_W-1:0] mem [bfa_pkg::BITMAP_WORDS];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/bfa_word_finder.sv @@
`timescale 1ns / 1ps

module bfa_word_finder (
  input  logic                        clk,
  input  logic                        rst,
  input  bfa_pkg::full_upd_t          upd,
  input  logic                        start,
  output logic [bfa_pkg::WORD_AW-1:0] word_addr,
  output logic                        word_found
);

  logic [bfa_pkg::BITMAP_WORDS-1:0] full;
  logic [bfa_pkg::NUM_GROUPS-1:0]   grp_full;
  logic [bfa_pkg::GRP_AW-1:0]       grp_idx;
  logic                             grp_found;
  logic [bfa_pkg::GROUP_SIZE-1:0]   grp_flags;
  logic [bfa_pkg::SLOT_AW-1:0]      slot;

  // One flag per memory word, set while the word has no clear bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0;
    end else if (upd.we) begin
      full[upd.addr] <= upd.full;
    end
  end

  // A group is full when all of its words are full.
  always_comb begin
    for (int g = 0; g < bfa_pkg::NUM_GROUPS; g++) begin
      grp_full[g] = &full[g*bfa_pkg::GROUP_SIZE +: bfa_pkg::GROUP_SIZE];
    end
  end

  // First level: pick the lowest group with room and hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      grp_idx   <= bfa_pkg::lowest_zero_group(grp_full);
      grp_found <= ~(&grp_full);
    end
  end

  // Second level: the lowest word with room inside that group.
  assign grp_flags  = full[{grp_idx, {bfa_pkg::SLOT_AW{1'b0}}} +: bfa_pkg::GROUP_SIZE];
  assign slot       = bfa_pkg::lowest_zero_slot(grp_flags);
  assign word_addr  = {grp_idx, slot};
  assign word_found = grp_found;

endmodule

@@ sv/bitmap_frame_allocator.sv @@
`timescale 1ns / 1ps
// Sequence: an allocate passes through group search, word search and memory read,
// modify and write-back, and result load; free and reserve go to modify and write-back,
// then result load; an index beyond the table or an unused mode goes to result load.
// One word is in work at a time, so a new word is not taken before the last result is loaded.
// Reset: after rst the bitmap memory is zeroed one word per cycle, during which
// s_tready stays low; the free count resets to 32768.
module bitmap_frame_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bfa_pkg::FRAME_IN_W-1:0]  s_tdata,  // [15:0] frame_in
  input  logic [bfa_pkg::MODE_W-1:0]      s_tuser,  // [1:0] mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bfa_pkg::OUT_TDATA_W-1:0] m_tdata   // [14:0] frame_out, [16:15] status,
                                                    // [32:17] free_frames, rest zero
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WORD,
    S_MODIFY,
    S_RESP
  } state_t;

  state_t                          state;
  logic [bfa_pkg::WORD_AW-1:0]     clear_addr;
  bfa_pkg::mode_t                  op;
  logic [bfa_pkg::FRAME_IN_W-1:0]  frame;
  logic [bfa_pkg::WORD_AW-1:0]     word_addr;
  logic [bfa_pkg::COUNT_W-1:0]     count;
  logic [bfa_pkg::FRAME_OUT_W-1:0] res_frame;
  bfa_pkg::status_t                res_status;

  logic                            accept;
  bfa_pkg::mode_t                  in_mode;
  logic [bfa_pkg::FRAME_IN_W-1:0]  in_frame;
  logic                            in_range;
  logic                            in_targeted;

  logic                            ram_we;
  logic [bfa_pkg::WORD_AW-1:0]     ram_waddr;
  logic [bfa_pkg::WORD_W-1:0]      ram_wdata;
  logic                            ram_re;
  logic [bfa_pkg::WORD_AW-1:0]     ram_raddr;
  logic [bfa_pkg::WORD_W-1:0]      ram_rdata;

  bfa_pkg::full_upd_t              upd;
  logic [bfa_pkg::WORD_AW-1:0]     found_addr;
  logic                            found;

  logic [bfa_pkg::BIT_AW-1:0]      bit_sel;
  logic [bfa_pkg::WORD_W-1:0]      mask;
  logic                            cur_used;
  logic [bfa_pkg::WORD_W-1:0]      new_word;
  logic                            flip;

  // Input handshake and field decode.
  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid & s_tready;
  assign in_mode     = bfa_pkg::mode_t'(s_tuser);
  assign in_frame    = s_tdata;
  assign in_range    = in_frame < bfa_pkg::FRAME_IN_W'(bfa_pkg::TOTAL_FRAMES);
  assign in_targeted = (in_mode == bfa_pkg::MODE_FREE) || (in_mode == bfa_pkg::MODE_RESERVE);

  // Read the target word straight from the input, or the word the search found.
  assign ram_re    = (accept && in_targeted && in_range) || (state == S_WORD && found);
  assign ram_raddr = (state == S_WORD) ? found_addr
                                       : in_frame[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];

  // Modify the word that came back from memory.
  always_comb begin
    bit_sel  = (op == bfa_pkg::MODE_ALLOC) ? bfa_pkg::lowest_zero_bit(ram_rdata)
                                           : frame[bfa_pkg::BIT_AW-1:0];
    mask     = bfa_pkg::WORD_W'(1) << bit_sel;
    cur_used = |(ram_rdata & mask);
    new_word = (op == bfa_pkg::MODE_FREE) ? (ram_rdata & ~mask) : (ram_rdata | mask);
    unique case (op)
      bfa_pkg::MODE_ALLOC:   flip = 1'b1;
      bfa_pkg::MODE_FREE:    flip = cur_used;
      bfa_pkg::MODE_RESERVE: flip = ~cur_used;
      default:               flip = 1'b0;
    endcase
  end

  // Write-back, or zero fill while clearing after reset.
  assign ram_we    = (state == S_CLEAR) || (state == S_MODIFY && flip);
  assign ram_waddr = (state == S_CLEAR) ? clear_addr : word_addr;
  assign ram_wdata = (state == S_CLEAR) ? '0 : new_word;

  assign upd.we   = (state == S_MODIFY) && flip;
  assign upd.addr = word_addr;
  assign upd.full = &new_word;

  bfa_bitmap_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfa_word_finder u_finder (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .start      (accept),
    .word_addr  (found_addr),
    .word_found (found)
  );

  // Sequencer, free count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      count      <= bfa_pkg::COUNT_W'(bfa_pkg::TOTAL_FRAMES);
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + bfa_pkg::WORD_AW'(1);
          if (clear_addr == bfa_pkg::WORD_AW'(bfa_pkg::BITMAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op         <= in_mode;
            frame      <= in_frame;
            word_addr  <= in_frame[bfa_pkg::BIT_AW +: bfa_pkg::WORD_AW];
            res_frame  <= '0;
            res_status <= (in_targeted && !in_range) ? bfa_pkg::ST_RANGE : bfa_pkg::ST_OK;
            if (in_mode == bfa_pkg::MODE_ALLOC) begin
              state <= S_WORD;
            end else if (in_targeted && in_range) begin
              state <= S_MODIFY;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_WORD: begin
          if (found) begin
            word_addr <= found_addr;
            state     <= S_MODIFY;
          end else begin
            res_status <= bfa_pkg::ST_OOM;
            state      <= S_RESP;
          end
        end
        S_MODIFY: begin
          if (op == bfa_pkg::MODE_ALLOC) begin
            res_frame <= bfa_pkg::FRAME_OUT_W'({word_addr, bit_sel});
          end
          if (flip) begin
            count <= (op == bfa_pkg::MODE_FREE) ? count + bfa_pkg::COUNT_W'(1)
                                                : count - bfa_pkg::COUNT_W'(1);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= bfa_pkg::OUT_TDATA_W'({count, res_status, res_frame});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The free count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bfa_pkg::COUNT_W'(bfa_pkg::TOTAL_FRAMES))
    else $error("free count above table size");

  // Out of memory is only reported when no frame is free.
  a_oom_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[bfa_pkg::FRAME_OUT_W +: bfa_pkg::STATUS_W] == bfa_pkg::ST_OOM)
    |-> (m_tdata[bfa_pkg::FRAME_OUT_W + bfa_pkg::STATUS_W +: bfa_pkg::COUNT_W] == '0))
    else $error("out of memory reported with free frames left");

  // The word chosen for an allocation always has a clear bit.
  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODIFY && op == bfa_pkg::MODE_ALLOC) |-> !(&ram_rdata))
    else $error("allocation landed on a full word");

  // Reads and writes of the bitmap never share a cycle.
  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("bitmap read and write in the same cycle");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Mode code that the block must ignore.
  localparam logic [bfa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int MAX_REPORTS = 60;

  typedef struct packed {
    logic [bfa_pkg::FRAME_OUT_W-1:0] frame_out;
    bfa_pkg::status_t                status;
    logic [bfa_pkg::COUNT_W-1:0]     free_frames;
  } reply_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [bfa_pkg::FRAME_IN_W-1:0]  s_tdata = '0;
  logic [bfa_pkg::MODE_W-1:0]      s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [bfa_pkg::OUT_TDATA_W-1:0] m_tdata;

  // Shadow copy of the frame table and its free count.
  logic [bfa_pkg::WORD_W-1:0] used_map [bfa_pkg::BITMAP_WORDS];
  int                         free_left;

  reply_t            pending_replies [$];
  logic [15:0]       held_frames [$];
  bit                calm = 1'b0;
  int                err_count = 0;
  int unsigned       cycle_count = 0;
  int                stall_left = 0;

  bitmap_frame_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one operation to the shadow table and returns the reply it must produce.
  function automatic reply_t frame_table_update(input logic [bfa_pkg::MODE_W-1:0] op,
                                                input logic [bfa_pkg::FRAME_IN_W-1:0] frame);
    reply_t                     r;
    bit                         found;
    int                         w;
    int                         b;
    logic [bfa_pkg::WORD_W-1:0] m;
    r.frame_out = '0;
    r.status    = bfa_pkg::ST_OK;
    case (op)
      bfa_pkg::MODE_ALLOC: begin
        found = 1'b0;
        for (w = 0; w < bfa_pkg::BITMAP_WORDS && !found; w++) begin
          if (used_map[w] != '1) begin
            for (b = 0; b < bfa_pkg::WORD_W && !found; b++) begin
              if (!used_map[w][b]) begin
                used_map[w][b] = 1'b1;
                free_left--;
                r.frame_out = bfa_pkg::FRAME_OUT_W'(w * bfa_pkg::WORD_W + b);
                found = 1'b1;
              end
            end
          end
        end
        if (!found) r.status = bfa_pkg::ST_OOM;
      end
      bfa_pkg::MODE_FREE, bfa_pkg::MODE_RESERVE: begin
        if (int'(frame) >= bfa_pkg::TOTAL_FRAMES) begin
          r.status = bfa_pkg::ST_RANGE;
        end else begin
          w = int'(frame) / bfa_pkg::WORD_W;
          m = bfa_pkg::WORD_W'(1) << (int'(frame) % bfa_pkg::WORD_W);
          if (op == bfa_pkg::MODE_FREE && (used_map[w] & m) != '0) begin
            used_map[w] = used_map[w] & ~m;
            free_left++;
          end else if (op == bfa_pkg::MODE_RESERVE && (used_map[w] & m) == '0) begin
            used_map[w] = used_map[w] | m;
            free_left--;
          end
        end
      end
      default: begin
      end
    endcase
    r.free_frames = bfa_pkg::COUNT_W'(free_left);
    return r;
  endfunction

  // Sends one word, waits for the handshake and records the reply it must cause.
  task automatic send_op(input logic [bfa_pkg::MODE_W-1:0] op,
                         input logic [bfa_pkg::FRAME_IN_W-1:0] frame,
                         output reply_t r);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= frame;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    r = frame_table_update(op, frame);
    pending_replies.push_back(r);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Edges of the fields, every mode, double free and reserve, range errors, unused mode.
  task automatic test_directed();
    reply_t r;
    send_op(bfa_pkg::MODE_ALLOC, 16'h0000, r);
    send_op(bfa_pkg::MODE_ALLOC, 16'hFFFF, r);
    send_op(bfa_pkg::MODE_RESERVE, 16'd2, r);
    send_op(bfa_pkg::MODE_ALLOC, 16'd0, r);
    send_op(bfa_pkg::MODE_FREE, 16'd0, r);
    send_op(bfa_pkg::MODE_ALLOC, 16'd0, r);
    send_op(bfa_pkg::MODE_FREE, 16'd5, r);
    send_op(bfa_pkg::MODE_RESERVE, 16'd2, r);
    send_op(bfa_pkg::MODE_RESERVE, 16'd63, r);
    send_op(bfa_pkg::MODE_RESERVE, 16'd64, r);
    send_op(bfa_pkg::MODE_FREE, 16'd63, r);
    send_op(bfa_pkg::MODE_FREE, 16'(bfa_pkg::TOTAL_FRAMES - 1), r);
    send_op(bfa_pkg::MODE_RESERVE, 16'(bfa_pkg::TOTAL_FRAMES - 1), r);
    send_op(bfa_pkg::MODE_FREE, 16'(bfa_pkg::TOTAL_FRAMES - 1), r);
    send_op(bfa_pkg::MODE_FREE, 16'(bfa_pkg::TOTAL_FRAMES), r);
    send_op(bfa_pkg::MODE_RESERVE, 16'(bfa_pkg::TOTAL_FRAMES), r);
    send_op(bfa_pkg::MODE_RESERVE, 16'hFFFF, r);
    send_op(bfa_pkg::MODE_FREE, 16'hFFFF, r);
    send_op(MODE_UNUSED, 16'h0000, r);
    send_op(MODE_UNUSED, 16'hFFFF, r);
    send_op(bfa_pkg::MODE_FREE, 16'd1, r);
    send_op(bfa_pkg::MODE_FREE, 16'd3, r);
    send_op(bfa_pkg::MODE_FREE, 16'd2, r);
    send_op(bfa_pkg::MODE_FREE, 16'd64, r);
  endtask

  // Mostly allocate and free of held frames, with stray indexes and noise mixed in.
  task automatic test_random_ops(input int n_items);
    reply_t                         r;
    int                             pick;
    int                             idx;
    logic [bfa_pkg::MODE_W-1:0]     op;
    logic [bfa_pkg::FRAME_IN_W-1:0] frame;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 99);
      frame = 16'($urandom());
      if (pick < 40 || (pick < 65 && held_frames.size() == 0)) begin
        op = bfa_pkg::MODE_ALLOC;
      end else if (pick < 65) begin
        op    = bfa_pkg::MODE_FREE;
        idx   = $urandom_range(0, held_frames.size() - 1);
        frame = held_frames[idx];
        held_frames.delete(idx);
      end else if (pick < 73) begin
        op    = bfa_pkg::MODE_RESERVE;
        frame = 16'($urandom_range(0, bfa_pkg::TOTAL_FRAMES - 1));
      end else if (pick < 81) begin
        op    = bfa_pkg::MODE_FREE;
        frame = 16'($urandom_range(0, bfa_pkg::TOTAL_FRAMES - 1));
      end else if (pick < 89) begin
        op    = $urandom_range(0, 1) ? bfa_pkg::MODE_FREE : bfa_pkg::MODE_RESERVE;
        frame = 16'($urandom_range(0, 255));
      end else if (pick < 95) begin
        op    = $urandom_range(0, 1) ? bfa_pkg::MODE_FREE : bfa_pkg::MODE_RESERVE;
        frame = 16'($urandom_range(bfa_pkg::TOTAL_FRAMES, 65535));
      end else begin
        op = MODE_UNUSED;
      end
      send_op(op, frame, r);
      if (op == bfa_pkg::MODE_ALLOC && r.status == bfa_pkg::ST_OK) begin
        held_frames.push_back(16'(r.frame_out));
      end
    end
    calm = 1'b0;
  endtask

  // Allocates a run of frames across word boundaries, then works near the lowest frames.
  task automatic test_fill_run();
    reply_t r;
    calm = 1'b1;
    repeat (96) send_op(bfa_pkg::MODE_ALLOC, 16'($urandom()), r);
    send_op(bfa_pkg::MODE_ALLOC, 16'h0000, r);
    send_op(bfa_pkg::MODE_ALLOC, 16'hFFFF, r);
    send_op(bfa_pkg::MODE_RESERVE, 16'd100, r);
    send_op(bfa_pkg::MODE_FREE, 16'd777, r);
    send_op(bfa_pkg::MODE_FREE, 16'(bfa_pkg::TOTAL_FRAMES - 1), r);
    send_op(bfa_pkg::MODE_ALLOC, 16'd0, r);
    send_op(bfa_pkg::MODE_ALLOC, 16'd0, r);
    send_op(bfa_pkg::MODE_ALLOC, 16'd0, r);
    send_op(bfa_pkg::MODE_FREE, 16'd0, r);
    send_op(bfa_pkg::MODE_RESERVE, 16'd0, r);
    send_op(bfa_pkg::MODE_ALLOC, 16'd0, r);
    held_frames.delete();
    calm = 1'b0;
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < bfa_pkg::BITMAP_WORDS; i++) used_map[i] = '0;
    free_left = bfa_pkg::TOTAL_FRAMES;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_ops(300);
    test_fill_run();
    test_random_ops(300);
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm) stall_left = pick_gap();
    end
  end

  // Compares each result word with the oldest pending reply.
  always @(posedge clk) begin : check_replies
    reply_t want;
    reply_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got.frame_out   = m_tdata[bfa_pkg::FRAME_OUT_W-1:0];
      got.status      = bfa_pkg::status_t'(m_tdata[bfa_pkg::FRAME_OUT_W +: bfa_pkg::STATUS_W]);
      got.free_frames = m_tdata[bfa_pkg::FRAME_OUT_W + bfa_pkg::STATUS_W +: bfa_pkg::COUNT_W];
      if (pending_replies.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected result word, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (got.frame_out !== want.frame_out) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: frame_out expected %0d actual %0d", $time,
                     want.frame_out, got.frame_out);
        end
        if (got.status !== want.status) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.free_frames !== want.free_frames) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: free_frames expected %0d actual %0d", $time,
                     want.free_frames, got.free_frames);
        end
        if (m_tdata[bfa_pkg::OUT_TDATA_W-1:bfa_pkg::OUT_FIELDS_W] !== '0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: padding expected 0 actual %h", $time,
                     m_tdata[bfa_pkg::OUT_TDATA_W-1:bfa_pkg::OUT_FIELDS_W]);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule

@@ sim.f @@
sv/bfa_pkg.sv
sv/bfa_bitmap_ram.sv
sv/bfa_word_finder.sv
sv/bitmap_frame_allocator.sv
test/tb.sv
